### sv/dkq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dkq_pkg;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_BITS_DEF  = 32;
  localparam int TAG_BITS_DEF  = 16;
endpackage
`default_nettype wire

### sv/dkq_store.sv
`timescale 1ns / 1ps
`default_nettype none
module dkq_store #(
  parameter int DEPTH = dkq_pkg::MAX_ITEMS_DEF,
  parameter int WIDTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/descending_key_tag_quicksort_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Descending key/tag sorter.
// Input stream s_axis: tdata = {ordinal, distance}, tlast marks the final
// item of a set. Items load one beat per cycle into an item memory; items
// beyond MAX_ITEMS are dropped, and a dropped tlast beat still starts the sort.
// After the tlast beat, s_axis_tready drops and a Hoare quicksort (middle
// pivot, explicit range stack) runs with one memory read port and one write
// port under a small sequencer. A range pop with pivot fetch steps through
// the stack read, pop, pivot address and pivot read states; each scan step
// is an address state then a registered read check, each swap writes both
// items in turn, and the right then left push checks follow.
// The sorted run then streams out on m_axis, largest distance first, with
// tlast on the final beat; each beat is read, then presented, and once the
// final beat is taken the block returns to loading.
// A stalled receiver holds the output register and the sequencer waits.
// Reset empties the set and returns to loading; memory contents are kept.
module descending_key_tag_quicksort_top #(
  parameter int MAX_ITEMS = dkq_pkg::MAX_ITEMS_DEF,
  parameter int KEY_BITS  = dkq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS  = dkq_pkg::TAG_BITS_DEF,
  localparam int DW = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [DW-1:0] s_axis_tdata,   // distance, ordinal, zero fill
  input  wire logic          s_axis_tlast,   // last_item
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [DW-1:0] m_axis_tdata,   // sorted_distance, sorted_ordinal, zero fill
  output logic               m_axis_tlast    // last_result
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = KEY_BITS + TAG_BITS;
  localparam int SW = AW + 2;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_POPRD, S_POP, S_PIVRD, S_PIV, S_LRD, S_LCHK,
    S_HRD, S_HCHK, S_SWA, S_SWB, S_PUSHR, S_PUSHL, S_ORD, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [AW-1:0] lo, hi;
  logic signed [SW-1:0] sl, sh;
  logic signed [SW-1:0] lo_s, hi_s;
  logic [KEY_BITS-1:0] pivot;
  logic [IW-1:0] item_l, item_h;
  logic [CW-1:0] sp;
  logic [AW-1:0] stk_lo [MAX_ITEMS];
  logic [AW-1:0] stk_hi [MAX_ITEMS];
  logic [AW-1:0] pop_lo, pop_hi;
  logic [CW-1:0] oidx;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [IW-1:0] wdata, rdata;
  logic [AW:0]   mid_sum;
  logic [KEY_BITS-1:0] rkey;

  assign rkey = rdata[KEY_BITS-1:0];
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign lo_s = {2'b00, lo};
  assign hi_s = {2'b00, hi};
  assign s_axis_tready = (state == S_LOAD);

  dkq_store #(.DEPTH(MAX_ITEMS), .WIDTH(IW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    pop_lo <= stk_lo[sp[AW-1:0] - AW'(1)];
    pop_hi <= stk_hi[sp[AW-1:0] - AW'(1)];
  end

  always_comb begin
    we = 1'b0;
    waddr = sl[AW-1:0];
    wdata = item_h;
    raddr = sl[AW-1:0];
    unique case (state)
      S_LOAD: begin
        we = s_axis_tvalid && (count < CW'(MAX_ITEMS));
        waddr = count[AW-1:0];
        wdata = s_axis_tdata[IW-1:0];
      end
      S_PIVRD: raddr = mid_sum[AW:1];
      S_LRD: raddr = sl[AW-1:0];
      S_HRD: raddr = sh[AW-1:0];
      S_SWA: begin
        we = 1'b1;
        waddr = sl[AW-1:0];
        wdata = item_h;
      end
      S_SWB: begin
        we = 1'b1;
        waddr = sh[AW-1:0];
        wdata = item_l;
      end
      S_ORD: raddr = oidx[AW-1:0];
      default: raddr = sl[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      sp <= '0;
      sl <= '0;
      sh <= '0;
      pivot <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (s_axis_tvalid) begin
          if (count < CW'(MAX_ITEMS)) count <= count + CW'(1);
          if (s_axis_tlast) state <= S_INIT;
        end
        S_INIT: begin
          oidx <= '0;
          if (count > CW'(1)) begin
            stk_lo[AW'(0)] <= '0;
            stk_hi[AW'(0)] <= AW'(count - CW'(1));
            sp <= CW'(1);
            state <= S_POPRD;
          end else begin
            sp <= '0;
            state <= S_ORD;
          end
        end
        // let the stack read register settle on the current top
        S_POPRD: state <= S_POP;
        S_POP: begin
          if (sp == '0) begin
            state <= S_ORD;
          end else begin
            sp <= sp - CW'(1);
            lo <= pop_lo; hi <= pop_hi;
            sl <= {2'b00, pop_lo}; sh <= {2'b00, pop_hi};
            state <= S_PIVRD;
          end
        end
        S_PIVRD: state <= S_PIV;
        S_PIV: begin
          pivot <= rkey;
          state <= S_LRD;
        end
        S_LRD: state <= S_LCHK;
        S_LCHK: begin
          if (rkey > pivot && sl < hi_s) begin
            sl <= sl + SW'(1);
            state <= S_LRD;
          end else begin
            item_l <= rdata;
            state <= S_HRD;
          end
        end
        S_HRD: state <= S_HCHK;
        S_HCHK: begin
          if (pivot > rkey && sh > lo_s) begin
            sh <= sh - SW'(1);
            state <= S_HRD;
          end else if (sl <= sh) begin
            item_h <= rdata;
            state <= S_SWA;
          end else begin
            state <= S_PUSHR;
          end
        end
        S_SWA: state <= S_SWB;
        S_SWB: begin
          // advance both scans past the swapped pair
          sl <= sl + SW'(1);
          sh <= sh - SW'(1);
          if (sl + SW'(1) <= sh - SW'(1)) state <= S_LRD;
          else state <= S_PUSHR;
        end
        S_PUSHR: begin
          if (sl < hi_s && sp < CW'(MAX_ITEMS)) begin
            stk_lo[sp[AW-1:0]] <= sl[AW-1:0];
            stk_hi[sp[AW-1:0]] <= hi;
            sp <= sp + CW'(1);
          end
          state <= S_PUSHL;
        end
        S_PUSHL: begin
          if (lo_s < sh && sp < CW'(MAX_ITEMS)) begin
            stk_lo[sp[AW-1:0]] <= lo;
            stk_hi[sp[AW-1:0]] <= sh[AW-1:0];
            sp <= sp + CW'(1);
          end
          state <= S_POPRD;
        end
        S_ORD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (oidx == count) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= DW'(rdata);
          m_axis_tlast <= (oidx + CW'(1) == count);
          oidx <= oidx + CW'(1);
          state <= S_ORD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("output pending while loading");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS)) else $error("count overflow");
  a_stack_cap: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(MAX_ITEMS)) else $error("stack overflow");
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int MAXN = dkq_pkg::MAX_ITEMS_DEF;
  localparam int DW = 48;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [31:0] dkey;
    logic [15:0] ord;
    logic        last;
  } beat_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  descending_key_tag_quicksort_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  beat_t pending_beats[$];
  beat_t sorted_expect[$];
  logic [31:0] set_keys[MAXN];
  logic [15:0] set_tags[MAXN];
  int set_len = 0;
  int errors = 0;
  int beats_in = 0, beats_out = 0, sets_done = 0;
  int cycles = 0;
  bit hold_long = 0;
  bit stim_done = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Hoare partition, middle pivot, both scans stop on equal keys.
  task automatic sort_set();
    int lo_q[$], hi_q[$];
    int lo, hi, i, j;
    logic [31:0] piv, tk;
    logic [15:0] tt;
    if (set_len > 1) begin
      lo_q.push_back(0); hi_q.push_back(set_len - 1);
    end
    while (lo_q.size() > 0) begin
      lo = lo_q.pop_back(); hi = hi_q.pop_back();
      i = lo; j = hi;
      piv = set_keys[(lo + hi) / 2];
      while (i <= j) begin
        while (set_keys[i] > piv && i < hi) i++;
        while (piv > set_keys[j] && j > lo) j--;
        if (i <= j) begin
          tk = set_keys[i]; tt = set_tags[i];
          set_keys[i] = set_keys[j]; set_tags[i] = set_tags[j];
          set_keys[j] = tk; set_tags[j] = tt;
          i++; j--;
        end
      end
      if (i < hi) begin lo_q.push_back(i); hi_q.push_back(hi); end
      if (lo < j) begin lo_q.push_back(lo); hi_q.push_back(j); end
    end
  endtask

  task automatic predict_beat(input beat_t b);
    beat_t r;
    if (set_len < MAXN) begin
      set_keys[set_len] = b.dkey;
      set_tags[set_len] = b.ord;
      set_len++;
    end
    if (b.last) begin
      sort_set();
      for (int k = 0; k < set_len; k++) begin
        r.dkey = set_keys[k];
        r.ord = set_tags[k];
        r.last = (k == set_len - 1);
        sorted_expect.push_back(r);
      end
      set_len = 0;
      sets_done++;
    end
  endtask

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    beat_t nb;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat({s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tlast});
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 0;
        end else if (pending_beats.size() > 0 && pending_beats[0].ord === 16'hxxxx) begin
          // drain marker: pause until every expected result is out
          if (sorted_expect.size() == 0 && !(s_axis_tvalid && s_axis_tready)) begin
            void'(pending_beats.pop_front());
          end
          s_axis_tvalid <= 0;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tdata <= {nb.ord, nb.dkey};
          s_axis_tlast <= nb.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
          end else burst_left--;
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_long) begin
      hold_cnt++;
      m_axis_tready <= 0;
      if (hold_cnt > 600) begin
        hold_long = 0;
        hold_cnt = 0;
      end
    end else begin
      m_axis_tready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (sorted_expect.size() == 0) begin
        report("unexpected beat", 64'(m_axis_tdata), 64'(0));
      end else begin
        w = sorted_expect.pop_front();
        if (m_axis_tdata[31:0] !== w.dkey)
          report("sorted_distance", 64'(m_axis_tdata[31:0]), 64'(w.dkey));
        if (m_axis_tdata[47:32] !== w.ord)
          report("sorted_ordinal", 64'(m_axis_tdata[47:32]), 64'(w.ord));
        if (m_axis_tlast !== w.last)
          report("last_result", 64'(m_axis_tlast), 64'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", sorted_expect.size());
      $display("descending_key_tag_quicksort_top regression: fail");
      $finish;
    end
  end

  task automatic add_beat(input logic [31:0] d, input logic [15:0] o, input logic l);
    beat_t b;
    b.dkey = d; b.ord = o; b.last = l;
    pending_beats.push_back(b);
  endtask

  task automatic add_pause();
    beat_t b;
    b.dkey = '0; b.ord = 16'hxxxx; b.last = 0;
    pending_beats.push_back(b);
  endtask

  task automatic add_random_set(input int n, input int kmode);
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      case (kmode)
        0: d = $urandom();
        1: d = $urandom_range(0, 3);
        default: d = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      add_beat(d, $urandom_range(0, 65535), i == n - 1);
    end
  endtask

  initial begin
    int total;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: single item, two items, extremes, ties
    add_beat(32'h0000_0000, 16'h0000, 1);
    add_beat(32'hFFFF_FFFF, 16'hFFFF, 1);
    add_beat(32'h0000_0001, 16'h0001, 0);
    add_beat(32'hFFFF_FFFF, 16'h0002, 1);
    add_beat(32'h5, 16'hA, 0); add_beat(32'h5, 16'hB, 0);
    add_beat(32'h5, 16'hC, 0); add_beat(32'h7, 16'hD, 1);
    add_beat(32'h1, 16'h1, 0); add_beat(32'h2, 16'h2, 0);
    add_beat(32'h3, 16'h3, 0); add_beat(32'h4, 16'h4, 1);
    add_beat(32'hAAAA_AAAA, 16'h5555, 0); add_beat(32'h5555_5555, 16'hAAAA, 1);
    add_pause();
    // overflow: more than MAX_ITEMS, extra dropped
    add_random_set(MAXN + 3, 0);
    add_pause();
    wait (pending_beats.size() == 0);
    hold_long = 1;
    add_random_set(MAXN, 1);
    add_random_set(8, 0);
    total = 0;
    while (total < 70) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAXN) : $urandom_range(1, 10);
      add_random_set(n, $urandom_range(0, 2));
      total += n;
      if ($urandom_range(0, 7) == 0) add_pause();
    end
    wait (pending_beats.size() == 0 && !s_axis_tvalid);
    wait (sorted_expect.size() == 0);
    repeat (200) @(posedge clk);
    $display("sorted %0d sets: %0d beats in, %0d beats out", sets_done, beats_in, beats_out);
    $display("ties, extremes, overflow past %0d items and long output stalls covered", MAXN);
    if (errors == 0 && sorted_expect.size() == 0)
      $display("descending_key_tag_quicksort_top regression: pass");
    else
      $display("descending_key_tag_quicksort_top regression: fail");
    $finish;
  end
endmodule
